// ===== rtl/cm3m_pkg.sv =====
// ----------------------------------------------------------------------------
// cm3m_pkg
// Shared types and constants of the 3x3 first-moment centroid block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cm3m_pkg;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_EDGE      = 2'd1;
	localparam status_t STATUS_NO_COUNTS = 2'd2;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int COORD_BITS     = 16;
	localparam int SIZE_BITS      = 15;
	localparam int OUT_BITS       = 33;

	// The offset limit is 2**LIMIT_LOG2 pixels.
	localparam int LIMIT_LOG2 = 7;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BACKGROUND   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_X0     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_Y0     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd4;

	localparam logic [SIZE_BITS-1:0] IMAGE_SIZE_RESET = 15'd4096;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		status_t                      status;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/cm3m_div.sv =====
// ----------------------------------------------------------------------------
// cm3m_div
// Pipelined restoring divider producing a clamped, signed Q-format offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cm3m_div #(
	parameter int NUM_BITS  = 22,
	parameter int DEN_BITS  = 24,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                           clk,
	input  wire logic                                           en,
	input  wire logic [NUM_BITS-1:0]                            num,
	input  wire logic [DEN_BITS-1:0]                            den,
	input  wire logic                                           neg,
	output logic signed [FRAC_BITS+cm3m_pkg::LIMIT_LOG2+1:0]    quo
);
	import cm3m_pkg::*;

	localparam int NB_BITS  = LIMIT_LOG2 + 1;
	localparam int QUO_BITS = FRAC_BITS + LIMIT_LOG2 + 1;
	localparam logic [QUO_BITS-1:0] LIM = QUO_BITS'(1) << (QUO_BITS - 1);

	logic [DEN_BITS-1:0] rem_s [QUO_BITS+1];
	logic [DEN_BITS-1:0] den_s [QUO_BITS+1];
	logic [QUO_BITS-1:0] q_s   [QUO_BITS+1];
	logic [NB_BITS-1:0]  nb_s  [QUO_BITS+1];
	logic                neg_s [QUO_BITS+1];
	logic                sat_s [QUO_BITS+1];

	logic [QUO_BITS-1:0] mag;

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0] <= {{(DEN_BITS+NB_BITS){1'b0}}, num} >=
				{{NUM_BITS{1'b0}}, den, {NB_BITS{1'b0}}};
			rem_s[0] <= DEN_BITS'(num >> NB_BITS);
			nb_s[0]  <= num[NB_BITS-1:0];
			den_s[0] <= den;
			neg_s[0] <= neg;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
		logic [DEN_BITS:0] trial;
		logic              fits;

		assign trial = {rem_s[k], nb_s[k][NB_BITS-1]};
		assign fits  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? DEN_BITS'(trial - {1'b0, den_s[k]}) : DEN_BITS'(trial);
				q_s[k+1]   <= {q_s[k][QUO_BITS-2:0], fits};
				nb_s[k+1]  <= nb_s[k] << 1;
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign mag = (sat_s[QUO_BITS] || q_s[QUO_BITS] > LIM) ? LIM : q_s[QUO_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QUO_BITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

`default_nettype wire

// ===== rtl/centroid_3x3_moment_top.sv =====
// ----------------------------------------------------------------------------
// centroid_3x3_moment_top
// First-moment centroid of a 3x3 pixel window with edge and no-counts checks.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while in_stall is low; the division
// pipeline resolves one quotient bit per stage and sets the depth.
// Reset clears every valid bit and loads the register defaults: background,
// origin zero and a 4096 by 4096 image.
`timescale 1ns / 1ps
`default_nettype none

module centroid_3x3_moment_top #(
	parameter int PIXEL_BITS    = 20,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       cfg_valid,
	output logic                                            cfg_ready,
	input  wire logic [cm3m_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  wire logic [cm3m_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	input  wire logic                                       in_valid,
	output logic                                            in_stall,
	input  wire logic signed [cm3m_pkg::COORD_BITS-1:0]     center_x,
	input  wire logic signed [cm3m_pkg::COORD_BITS-1:0]     center_y,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_l_u,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_c_u,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_r_u,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_l_c,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_c_c,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_r_c,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_l_d,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_c_d,
	input  wire logic signed [PIXEL_BITS-1:0]               pix_r_d,
	output logic                                            out_valid,
	input  wire logic                                       out_stall,
	output logic signed [cm3m_pkg::OUT_BITS-1:0]            centroid_x_q16,
	output logic signed [cm3m_pkg::OUT_BITS-1:0]            centroid_y_q16,
	output cm3m_pkg::status_t                               status
);
	import cm3m_pkg::*;

	localparam int LINE_BITS = PIXEL_BITS + 2;
	localparam int BG9_BITS  = PIXEL_BITS + 4;
	localparam int SUM_BITS  = PIXEL_BITS + 5;
	localparam int MOM_BITS  = PIXEL_BITS + 3;
	localparam int AMOM_BITS = PIXEL_BITS + 2;
	localparam int ASUM_BITS = PIXEL_BITS + 4;
	localparam int QUO_W     = FRACTION_BITS + LIMIT_LOG2 + 2;
	localparam int POS_BITS  = COORD_BITS + FRACTION_BITS + 1;
	localparam int DLY       = FRACTION_BITS + LIMIT_LOG2 + 3;
	localparam int EDGE_BITS = COORD_BITS + 2;

	logic signed [PIXEL_BITS-1:0] background_q;
	logic signed [COORD_BITS-1:0] image_x0_q;
	logic signed [COORD_BITS-1:0] image_y0_q;
	logic [SIZE_BITS-1:0]         image_width_q;
	logic [SIZE_BITS-1:0]         image_height_q;

	logic en;
	logic signed [EDGE_BITS-1:0] xe, ye, wm1, hm1;
	logic                        edge_hit;

	logic                         v_s1;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1;
	logic                         edge_s1;
	logic signed [LINE_BITS-1:0]  col_l_s1, col_c_s1, col_r_s1, row_u_s1, row_d_s1;
	logic signed [BG9_BITS-1:0]   bg9_s1;

	logic                         v_s2;
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2;
	logic                         edge_s2;
	logic signed [SUM_BITS-1:0]   sum_s2;
	logic signed [MOM_BITS-1:0]   mx_s2, my_s2;

	logic                         v_s3;
	side_t                        side_s3;
	logic                         negx_s3, negy_s3;
	logic [AMOM_BITS-1:0]         amx_s3, amy_s3;
	logic [ASUM_BITS-1:0]         asum_s3;

	logic                         v_d [DLY];
	side_t                        side_d [DLY];
	logic signed [QUO_W-1:0]      quo_x, quo_y;
	logic signed [POS_BITS-1:0]   px, py, sum_x, sum_y;

	logic                         out_valid_q;
	logic signed [OUT_BITS-1:0]   cent_x_q, cent_y_q;
	status_t                      status_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q   <= '0;
			image_x0_q     <= '0;
			image_y0_q     <= '0;
			image_width_q  <= IMAGE_SIZE_RESET;
			image_height_q <= IMAGE_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BACKGROUND:   background_q   <= cfg_data[PIXEL_BITS-1:0];
				REG_IMAGE_X0:     image_x0_q     <= cfg_data[COORD_BITS-1:0];
				REG_IMAGE_Y0:     image_y0_q     <= cfg_data[COORD_BITS-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	assign xe  = EDGE_BITS'(center_x) - EDGE_BITS'(image_x0_q);
	assign ye  = EDGE_BITS'(center_y) - EDGE_BITS'(image_y0_q);
	assign wm1 = $signed(EDGE_BITS'(image_width_q)) - EDGE_BITS'(1);
	assign hm1 = $signed(EDGE_BITS'(image_height_q)) - EDGE_BITS'(1);
	assign edge_hit = (xe < EDGE_BITS'(1)) || (xe >= wm1) ||
		(ye < EDGE_BITS'(1)) || (ye >= hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DLY; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d[0] <= v_s3;
			for (int i = 1; i < DLY; i++) begin
				v_d[i] <= v_d[i-1];
			end
			out_valid_q <= v_d[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1    <= center_x;
			cy_s1    <= center_y;
			edge_s1  <= edge_hit;
			col_l_s1 <= LINE_BITS'(pix_l_u) + LINE_BITS'(pix_l_c) + LINE_BITS'(pix_l_d);
			col_c_s1 <= LINE_BITS'(pix_c_u) + LINE_BITS'(pix_c_c) + LINE_BITS'(pix_c_d);
			col_r_s1 <= LINE_BITS'(pix_r_u) + LINE_BITS'(pix_r_c) + LINE_BITS'(pix_r_d);
			row_u_s1 <= LINE_BITS'(pix_l_u) + LINE_BITS'(pix_c_u) + LINE_BITS'(pix_r_u);
			row_d_s1 <= LINE_BITS'(pix_l_d) + LINE_BITS'(pix_c_d) + LINE_BITS'(pix_r_d);
			bg9_s1   <= (BG9_BITS'(background_q) <<< 3) + BG9_BITS'(background_q);

			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			edge_s2 <= edge_s1;
			sum_s2  <= SUM_BITS'(col_l_s1) + SUM_BITS'(col_c_s1) + SUM_BITS'(col_r_s1) -
				SUM_BITS'(bg9_s1);
			mx_s2   <= MOM_BITS'(col_r_s1) - MOM_BITS'(col_l_s1);
			my_s2   <= MOM_BITS'(row_u_s1) - MOM_BITS'(row_d_s1);

			side_s3.cx <= cx_s2;
			side_s3.cy <= cy_s2;
			if (edge_s2) begin
				side_s3.status <= STATUS_EDGE;
			end else if (sum_s2 == '0) begin
				side_s3.status <= STATUS_NO_COUNTS;
			end else begin
				side_s3.status <= STATUS_OK;
			end
			negx_s3 <= mx_s2[MOM_BITS-1] ^ sum_s2[SUM_BITS-1];
			negy_s3 <= my_s2[MOM_BITS-1] ^ sum_s2[SUM_BITS-1];
			amx_s3  <= mx_s2[MOM_BITS-1] ? AMOM_BITS'(-mx_s2) : AMOM_BITS'(mx_s2);
			amy_s3  <= my_s2[MOM_BITS-1] ? AMOM_BITS'(-my_s2) : AMOM_BITS'(my_s2);
			asum_s3 <= sum_s2[SUM_BITS-1] ? ASUM_BITS'(-sum_s2) : ASUM_BITS'(sum_s2);

			side_d[0] <= side_s3;
			for (int i = 1; i < DLY; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	cm3m_div #(
		.NUM_BITS (AMOM_BITS),
		.DEN_BITS (ASUM_BITS),
		.FRAC_BITS(FRACTION_BITS)
	) u_div_x (
		.clk(clk),
		.en (en),
		.num(amx_s3),
		.den(asum_s3),
		.neg(negx_s3),
		.quo(quo_x)
	);

	cm3m_div #(
		.NUM_BITS (AMOM_BITS),
		.DEN_BITS (ASUM_BITS),
		.FRAC_BITS(FRACTION_BITS)
	) u_div_y (
		.clk(clk),
		.en (en),
		.num(amy_s3),
		.den(asum_s3),
		.neg(negy_s3),
		.quo(quo_y)
	);

	assign px    = POS_BITS'(side_d[DLY-1].cx) <<< FRACTION_BITS;
	assign py    = POS_BITS'(side_d[DLY-1].cy) <<< FRACTION_BITS;
	assign sum_x = px + POS_BITS'(quo_x);
	assign sum_y = py + POS_BITS'(quo_y);

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= side_d[DLY-1].status;
			if (side_d[DLY-1].status == STATUS_OK) begin
				cent_x_q <= OUT_BITS'(sum_x);
				cent_y_q <= OUT_BITS'(sum_y);
			end else begin
				cent_x_q <= OUT_BITS'(px);
				cent_y_q <= OUT_BITS'(py);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign centroid_x_q16 = cent_x_q;
	assign centroid_y_q16 = cent_y_q;
	assign status         = status_q;

endmodule

`default_nettype wire

// ===== tb/tb_centroid_3x3_moment_top.sv =====
// ----------------------------------------------------------------------------
// tb_centroid_3x3_moment_top
// Self-checking bench for the 3x3 first-moment centroid block.
// Each accepted window is predicted from a local copy of the registers, and
// the results are compared field by field, in order. Registers change only
// while the block is empty. Directed cases cover the image edges, zero sums,
// offset clamping and pixel extremes. Random windows under several register
// settings follow, with idle bursts on both sides and a steady final stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_centroid_3x3_moment_top;
	import cm3m_pkg::*;

	localparam int PIX_BITS  = 20;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = FRAC_BITS + 14;
	localparam longint OFFSET_LIMIT = longint'(1) << (LIMIT_LOG2 + FRAC_BITS);
	localparam longint PIX_MAX = (longint'(1) << (PIX_BITS - 1)) - 1;
	localparam longint PIX_MIN = -(longint'(1) << (PIX_BITS - 1));
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

	localparam int LU = 0, CU = 1, RU = 2;
	localparam int LC = 3, CC = 4, RC = 5;
	localparam int LD = 6, CD = 7, RD = 8;

	typedef logic signed [PIX_BITS-1:0]   pix_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t      cx;
		coord_t      cy;
		pix_t [8:0]  pix;
	} window_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] x;
		logic signed [OUT_BITS-1:0] y;
		status_t                    status;
	} centroid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	coord_t center_x, center_y;
	pix_t pix_l_u, pix_c_u, pix_r_u, pix_l_c, pix_c_c, pix_r_c, pix_l_d, pix_c_d, pix_r_d;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_BITS-1:0] centroid_x_q16, centroid_y_q16;
	status_t status;

	longint bg_level, origin_x, origin_y, img_w, img_h;
	centroid_t pending_centroids[$];
	bit idle_on = 1'b1;
	int stall_left = 0;
	int n_errors = 0, n_checked = 0, n_cfg_writes = 0;
	int n_ok = 0, n_edge = 0, n_no_counts = 0;

	centroid_3x3_moment_top #(
		.PIXEL_BITS(PIX_BITS),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y),
		.pix_l_u(pix_l_u), .pix_c_u(pix_c_u), .pix_r_u(pix_r_u),
		.pix_l_c(pix_l_c), .pix_c_c(pix_c_c), .pix_r_c(pix_r_c),
		.pix_l_d(pix_l_d), .pix_c_d(pix_c_d), .pix_r_d(pix_r_d),
		.out_valid(out_valid), .out_stall(out_stall),
		.centroid_x_q16(centroid_x_q16), .centroid_y_q16(centroid_y_q16),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL centroid_3x3_moment_top");
		$finish;
	end

	function automatic longint pixel_value(window_t w, int k);
		return longint'(signed'(w.pix[k]));
	endfunction

	function automatic longint clamped_offset(longint moment, longint total);
		longint q;
		q = (moment * (longint'(1) << FRAC_BITS)) / total;
		if (q > OFFSET_LIMIT) q = OFFSET_LIMIT;
		if (q < -OFFSET_LIMIT) q = -OFFSET_LIMIT;
		return q;
	endfunction

	function automatic centroid_t predict_centroid(window_t w);
		centroid_t r;
		longint px, py, rel_x, rel_y, total, mx, my;
		px = longint'(signed'(w.cx)) * (longint'(1) << FRAC_BITS);
		py = longint'(signed'(w.cy)) * (longint'(1) << FRAC_BITS);
		rel_x = longint'(signed'(w.cx)) - origin_x;
		rel_y = longint'(signed'(w.cy)) - origin_y;
		r.status = STATUS_OK;
		if (rel_x < 1 || rel_x >= img_w - 1 || rel_y < 1 || rel_y >= img_h - 1) begin
			r.status = STATUS_EDGE;
		end else begin
			total = -9 * bg_level;
			for (int k = 0; k < 9; k++) total += pixel_value(w, k);
			if (total == 0) begin
				r.status = STATUS_NO_COUNTS;
			end else begin
				mx = pixel_value(w, RU) + pixel_value(w, RC) + pixel_value(w, RD)
					- pixel_value(w, LU) - pixel_value(w, LC) - pixel_value(w, LD);
				my = pixel_value(w, LU) + pixel_value(w, CU) + pixel_value(w, RU)
					- pixel_value(w, LD) - pixel_value(w, CD) - pixel_value(w, RD);
				px += clamped_offset(mx, total);
				py += clamped_offset(my, total);
			end
		end
		r.x = px[OUT_BITS-1:0];
		r.y = py[OUT_BITS-1:0];
		return r;
	endfunction

	function automatic pix_t clip_pixel(longint v);
		if (v > PIX_MAX) v = PIX_MAX;
		if (v < PIX_MIN) v = PIX_MIN;
		return pix_t'(v);
	endfunction

	function automatic window_t flat_window(longint cx, longint cy, longint level);
		window_t w;
		w.cx = coord_t'(cx);
		w.cy = coord_t'(cy);
		for (int k = 0; k < 9; k++) w.pix[k] = clip_pixel(level);
		return w;
	endfunction

	function automatic longint random_position(longint origin, longint size, int kind);
		if (kind < 7 && size >= 3)
			return origin + longint'($urandom_range(1, int'(size) - 2));
		if (kind < 8) begin
			if ($urandom_range(0, 1) == 0)
				return origin + longint'($urandom_range(0, 2));
			return origin + size - longint'($urandom_range(1, 3));
		end
		return longint'($urandom());
	endfunction

	// Mostly windows that land inside the image, with star-like, flat, near-zero
	// and exactly balanced pixel content; the rest is unconstrained noise.
	function automatic window_t random_window();
		window_t w;
		int kind, mode;
		longint rest;
		kind = $urandom_range(0, 9);
		mode = $urandom_range(0, 9);
		w.cx = coord_t'(random_position(origin_x, img_w, kind));
		w.cy = coord_t'(random_position(origin_y, img_h, $urandom_range(0, 9)));
		rest = 0;
		for (int k = 0; k < 9; k++) begin
			if (mode < 3)
				w.pix[k] = pix_t'($urandom());
			else if (mode < 6)
				w.pix[k] = clip_pixel(bg_level + longint'($urandom_range(0, 2000)));
			else if (mode < 8)
				w.pix[k] = clip_pixel(bg_level + longint'($urandom_range(0, 6)) - 3);
			else
				w.pix[k] = clip_pixel(bg_level + longint'($urandom_range(0, 2000)) - 1000);
			if (k != CC) rest += pixel_value(w, k);
		end
		if (mode >= 3 && mode < 6)
			w.pix[CC] = clip_pixel(pixel_value(w, CC) + longint'($urandom_range(0, 40000)));
		else if (mode >= 8)
			w.pix[CC] = clip_pixel(9 * bg_level - rest);
		return w;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] with_noise(longint v, int bits);
		logic [CFG_DATA_BITS-1:0] mask;
		mask = (32'h1 << bits) - 32'h1;
		return ($urandom() & ~mask) | (v[31:0] & mask);
	endfunction

	task automatic report_mismatch(input string what);
		if (n_errors < 50) $display("mismatch at %0t: %s", $time, what);
		n_errors++;
	endtask

	task automatic send_window(input window_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		center_x <= w.cx;
		center_y <= w.cy;
		pix_l_u <= w.pix[LU];
		pix_c_u <= w.pix[CU];
		pix_r_u <= w.pix[RU];
		pix_l_c <= w.pix[LC];
		pix_c_c <= w.pix[CC];
		pix_r_c <= w.pix[RC];
		pix_l_d <= w.pix[LD];
		pix_c_d <= w.pix[CD];
		pix_r_d <= w.pix[RD];
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_centroids.push_back(predict_centroid(w));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_centroids.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] word);
		cfg_index <= idx;
		cfg_data <= word;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BACKGROUND: begin
				bg_level = longint'(signed'(word[PIX_BITS-1:0]));
			end
			REG_IMAGE_X0: begin
				origin_x = longint'(signed'(word[COORD_BITS-1:0]));
			end
			REG_IMAGE_Y0: begin
				origin_y = longint'(signed'(word[COORD_BITS-1:0]));
			end
			REG_IMAGE_WIDTH: begin
				img_w = longint'(word[SIZE_BITS-1:0]);
			end
			REG_IMAGE_HEIGHT: begin
				img_h = longint'(word[SIZE_BITS-1:0]);
			end
			default: begin
			end
		endcase
		n_cfg_writes++;
	endtask

	task automatic set_config(longint bg, longint x0, longint y0, longint w, longint h);
		wait_idle();
		write_reg(REG_BACKGROUND, with_noise(bg, PIX_BITS));
		write_reg(REG_IMAGE_X0, with_noise(x0, COORD_BITS));
		write_reg(REG_IMAGE_Y0, with_noise(y0, COORD_BITS));
		write_reg(REG_IMAGE_WIDTH, with_noise(w, SIZE_BITS));
		write_reg(REG_IMAGE_HEIGHT, with_noise(h, SIZE_BITS));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		centroid_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_centroids.size() == 0) begin
				report_mismatch("result transaction with no window pending");
			end else begin
				want = pending_centroids.pop_front();
				n_checked++;
				if (centroid_x_q16 !== want.x)
					report_mismatch($sformatf("result %0d centroid_x_q16 %0d, want %0d",
						n_checked, centroid_x_q16, want.x));
				if (centroid_y_q16 !== want.y)
					report_mismatch($sformatf("result %0d centroid_y_q16 %0d, want %0d",
						n_checked, centroid_y_q16, want.y));
				if (status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						n_checked, status, want.status));
				case (want.status)
					STATUS_OK: n_ok++;
					STATUS_EDGE: n_edge++;
					default: n_no_counts++;
				endcase
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_reset_state();
		window_t w;
		w = flat_window(2048, 2048, 100);
		w.pix[CC] = pix_t'(5000);
		w.pix[RC] = pix_t'(900);
		w.pix[CU] = pix_t'(300);
		send_window(w);
		send_window(flat_window(0, 5, 10));
		w = flat_window(4094, 1, 7);
		w.pix[RD] = pix_t'(70);
		send_window(w);
		send_window(flat_window(4095, 10, 7));
		send_window(flat_window(100, 100, 0));
	endtask

	task automatic test_window_limits();
		window_t w;
		set_config(0, 100, -200, 3, 4);
		w = flat_window(101, -199, 20);
		w.pix[LU] = pix_t'(90);
		send_window(w);
		send_window(flat_window(100, -199, 20));
		send_window(flat_window(102, -199, 20));
		w = flat_window(101, -198, 20);
		w.pix[RD] = pix_t'(-50);
		send_window(w);
		send_window(flat_window(101, -197, 20));
		send_window(flat_window(101, -200, 20));
		set_config(0, 0, 0, 0, 32767);
		send_window(flat_window(1, 1, 20));
		set_config(-3, -32768, -32768, 32767, 32767);
		send_window(flat_window(32767, 10, 4));
		send_window(flat_window(-32767, -32767, 4));
		send_window(flat_window(-2, -3, 4));
		send_window(flat_window(-3, -2, 4));
	endtask

	task automatic test_moment_cases();
		window_t w;
		set_config(PIX_MIN, 0, 0, 4096, 4096);
		send_window(flat_window(32767, 500, PIX_MAX));
		set_config(PIX_MAX, 0, 0, 4096, 4096);
		send_window(flat_window(500, 32767, PIX_MIN));
		w = flat_window(600, 600, PIX_MAX);
		w.pix[CC] = pix_t'(PIX_MAX - 1);
		send_window(w);
		set_config(0, 0, 0, 4096, 4096);
		w = flat_window(700, 700, 0);
		w.pix[LU] = pix_t'(PIX_MIN);
		w.pix[RU] = pix_t'(PIX_MAX);
		send_window(w);
		w = flat_window(700, 701, 0);
		w.pix[RU] = pix_t'(PIX_MAX);
		w.pix[LD] = pix_t'(PIX_MIN);
		send_window(w);
		w = flat_window(701, 700, 0);
		w.pix[RU] = pix_t'(PIX_MAX);
		w.pix[LU] = pix_t'(PIX_MIN + 2);
		send_window(w);
		w = flat_window(702, 702, 0);
		w.pix[RC] = pix_t'(-1);
		w.pix[CC] = pix_t'(4);
		send_window(w);
		set_config(5, 0, 0, 4096, 4096);
		send_window(flat_window(800, 800, 5));
		w = flat_window(801, 801, 5);
		w.pix[CC] = pix_t'(6);
		send_window(w);
	endtask

	task automatic test_spare_index();
		window_t w;
		wait_idle();
		write_reg(REG_SPARE, $urandom());
		cfg_valid <= 1'b0;
		w = flat_window(2000, 2100, 5);
		w.pix[LC] = pix_t'(905);
		w.pix[CD] = pix_t'(105);
		send_window(w);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					set_config(0, 0, 0, 4096, 4096);
				end
				1: begin
					set_config(PIX_MIN, -32768, -32768, 32767, 32767);
				end
				2: begin
					set_config(PIX_MAX, 32767, 32767, 32767, 32767);
				end
				3: begin
					set_config($urandom(), $urandom(), $urandom(), 3, 5);
				end
				4: begin
					set_config($urandom(), $urandom(), $urandom(), $urandom(), 0);
				end
				default: begin
					set_config($urandom(), $urandom(), $urandom(),
						$urandom_range(0, 32767), $urandom_range(0, 32767));
				end
			endcase
			for (int k = 0; k < 130; k++) begin
				if (k == 65) wait_idle();
				send_window(random_window());
			end
		end
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		set_config(longint'($urandom_range(0, 2000)) - 1000, $urandom_range(0, 200),
			$urandom_range(0, 200), $urandom_range(64, 32767), $urandom_range(64, 32767));
		for (int k = 0; k < 200; k++) send_window(random_window());
	endtask

	initial begin
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		center_x <= '0;
		center_y <= '0;
		pix_l_u <= '0;
		pix_c_u <= '0;
		pix_r_u <= '0;
		pix_l_c <= '0;
		pix_c_c <= '0;
		pix_r_c <= '0;
		pix_l_d <= '0;
		pix_c_d <= '0;
		pix_r_d <= '0;
		bg_level = 0;
		origin_x = 0;
		origin_y = 0;
		img_w = longint'(IMAGE_SIZE_RESET);
		img_h = longint'(IMAGE_SIZE_RESET);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_window_limits();
		test_moment_cases();
		test_spare_index();
		test_random_settings();
		test_steady_stream();
		wait_idle();

		$display("Checked %0d centroid transactions: %0d ok, %0d at an edge, %0d with no counts.",
			n_checked, n_ok, n_edge, n_no_counts);
		$display("Register writes: %0d, over default, extreme, tiny and empty image settings.",
			n_cfg_writes);
		if (n_errors == 0) begin
			$display("PASS centroid_3x3_moment_top");
		end else begin
			$display("FAIL centroid_3x3_moment_top");
		end
		$finish;
	end

endmodule
